[rtl/core/cbsd_pkg.sv]
// Shared types and constants for the color blob swipe detector.
package cbsd_pkg;

    localparam int FRAME_WIDTH = 1024;

    localparam int HUE_W    = 8;
    localparam int SAT_W    = 8;
    localparam int VAL_W    = 8;
    localparam int COL_W    = 10;
    localparam int AREA_W   = 21;
    localparam int THR_W    = 10;
    localparam int COOL_W   = 8;
    localparam int SUM_W    = 30;
    localparam int CNT_W    = 21;
    localparam int GEST_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam logic [COL_W-1:0] COL_MAX =
        (FRAME_WIDTH >= (1 << COL_W)) ? {COL_W{1'b1}} : COL_W'(FRAME_WIDTH - 1);

    localparam logic [HUE_W-1:0]  HUE_LOW_RST  = 8'd90;
    localparam logic [HUE_W-1:0]  HUE_HIGH_RST = 8'd130;
    localparam logic [SAT_W-1:0]  SAT_LOW_RST  = 8'd50;
    localparam logic [VAL_W-1:0]  VAL_LOW_RST  = 8'd50;
    localparam logic [AREA_W-1:0] MIN_AREA_RST = 21'd500;
    localparam logic [THR_W-1:0]  THR_RST      = 10'd40;
    localparam logic [COOL_W-1:0] COOL_RST     = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW     = 3'd0,
        CFG_HUE_HIGH    = 3'd1,
        CFG_SAT_LOW     = 3'd2,
        CFG_VAL_LOW     = 3'd3,
        CFG_MIN_AREA    = 3'd4,
        CFG_SWIPE_THR   = 3'd5,
        CFG_COOLDOWN    = 3'd6
    } cfg_index_t;

    typedef enum logic [GEST_W-1:0] {
        GEST_NONE = 2'd0,
        GEST_NEXT = 2'd1,
        GEST_PREV = 2'd2
    } gesture_t;

    typedef enum logic [1:0] {
        ST_ACCUM  = 2'd0,
        ST_CHECK  = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_DONE   = 2'd3
    } state_t;

    typedef struct packed {
        logic pixel_ready;
        logic div_load;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_fire;
        logic seen;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

[rtl/core/cbsd_pixel_if.sv]
// Pixel input channel: valid/ready handshake with HSV pixel payload.
interface cbsd_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [cbsd_pkg::HUE_W-1:0]   hue;
    logic [cbsd_pkg::SAT_W-1:0]   saturation;
    logic [cbsd_pkg::VAL_W-1:0]   brightness;
    logic [cbsd_pkg::COL_W-1:0]   column;
    logic                         frame_end;

    modport source (output valid, hue, saturation, brightness, column, frame_end,
                    input ready);
    modport sink   (input valid, hue, saturation, brightness, column, frame_end,
                    output ready);
endinterface

[rtl/core/cbsd_result_if.sv]
// Result output channel: valid/ready handshake with per-frame gesture payload.
interface cbsd_result_if;
    logic                         valid;
    logic                         ready;
    logic [cbsd_pkg::GEST_W-1:0]  gesture;
    logic                         marker_seen;
    logic [cbsd_pkg::COL_W-1:0]   centroid;

    modport source (output valid, gesture, marker_seen, centroid, input ready);
    modport sink   (input valid, gesture, marker_seen, centroid, output ready);
endinterface

[rtl/core/cbsd_ctrl.sv]
// Frame sequencer: accumulate, area check, centroid divide, commit.
module cbsd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  cbsd_pkg::status_t status,
    output cbsd_pkg::cmd_t    cmd,
    output cbsd_pkg::state_t  state
);

    cbsd_pkg::state_t state_reg;
    cbsd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbsd_pkg::ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            cbsd_pkg::ST_ACCUM:
            begin
                cmd.pixel_ready = 1'b1;
                if (status.last_fire)
                begin
                    state_next = cbsd_pkg::ST_CHECK;
                end
            end
            cbsd_pkg::ST_CHECK:
            begin
                if (status.seen)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = cbsd_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = cbsd_pkg::ST_DONE;
                end
            end
            cbsd_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = cbsd_pkg::ST_DONE;
                end
            end
            cbsd_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = cbsd_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = cbsd_pkg::ST_ACCUM;
            end
        endcase
    end

    assign state = state_reg;

endmodule

[rtl/core/cbsd_datapath.sv]
// Datapath: config registers, pixel accumulators, serial divider, swipe logic.
module cbsd_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    cbsd_pixel_if.sink                          pixel,
    cbsd_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [cbsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbsd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  cbsd_pkg::cmd_t                      cmd,
    output cbsd_pkg::status_t                   status
);

    localparam int SW = cbsd_pkg::SUM_W;
    localparam int CW = cbsd_pkg::CNT_W;

    // configuration
    logic [cbsd_pkg::HUE_W-1:0]  hue_low_reg;
    logic [cbsd_pkg::HUE_W-1:0]  hue_high_reg;
    logic [cbsd_pkg::SAT_W-1:0]  sat_low_reg;
    logic [cbsd_pkg::VAL_W-1:0]  val_low_reg;
    logic [cbsd_pkg::AREA_W-1:0] min_area_reg;
    logic [cbsd_pkg::THR_W-1:0]  thr_reg;
    logic [cbsd_pkg::COOL_W-1:0] cool_frames_reg;

    // tracking state
    logic [SW-1:0]               sum_reg,  sum_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [cbsd_pkg::COL_W-1:0]  last_center_reg;
    logic                        last_valid_reg;
    logic [cbsd_pkg::COOL_W-1:0] cooldown_reg, cooldown_next;

    // divider
    logic [CW-1:0]                    rem_reg;
    logic [SW-1:0]                    quo_reg;
    logic [cbsd_pkg::DIV_STEP_W-1:0]  step_reg;
    logic [CW:0]                      rem_shift;
    logic [CW+1:0]                    rem_sub;

    // output register
    logic                        out_valid_reg;
    logic [cbsd_pkg::GEST_W-1:0] gesture_reg;
    logic                        seen_reg;
    logic [cbsd_pkg::COL_W-1:0]  centroid_reg;

    logic                        fire;
    logic                        match;
    logic [cbsd_pkg::COL_W-1:0]  col_clamped;
    logic [SW:0]                 sum_add;
    logic                        seen;
    logic [cbsd_pkg::COL_W-1:0]  center;
    logic signed [cbsd_pkg::COL_W+1:0] diff;
    logic signed [cbsd_pkg::COL_W+1:0] thr_s;
    logic                        swipe_ok;
    logic                        go_next;
    logic                        go_prev;
    logic [cbsd_pkg::COOL_W-1:0] cool_loaded;
    cbsd_pkg::gesture_t          gesture_next;

    assign pixel.ready = cmd.pixel_ready;
    assign fire        = pixel.valid && cmd.pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg     <= cbsd_pkg::HUE_LOW_RST;
            hue_high_reg    <= cbsd_pkg::HUE_HIGH_RST;
            sat_low_reg     <= cbsd_pkg::SAT_LOW_RST;
            val_low_reg     <= cbsd_pkg::VAL_LOW_RST;
            min_area_reg    <= cbsd_pkg::MIN_AREA_RST;
            thr_reg         <= cbsd_pkg::THR_RST;
            cool_frames_reg <= cbsd_pkg::COOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbsd_pkg::CFG_HUE_LOW:   hue_low_reg     <= cfg_data[cbsd_pkg::HUE_W-1:0];
                cbsd_pkg::CFG_HUE_HIGH:  hue_high_reg    <= cfg_data[cbsd_pkg::HUE_W-1:0];
                cbsd_pkg::CFG_SAT_LOW:   sat_low_reg     <= cfg_data[cbsd_pkg::SAT_W-1:0];
                cbsd_pkg::CFG_VAL_LOW:   val_low_reg     <= cfg_data[cbsd_pkg::VAL_W-1:0];
                cbsd_pkg::CFG_MIN_AREA:  min_area_reg    <= cfg_data[cbsd_pkg::AREA_W-1:0];
                cbsd_pkg::CFG_SWIPE_THR: thr_reg         <= cfg_data[cbsd_pkg::THR_W-1:0];
                cbsd_pkg::CFG_COOLDOWN:  cool_frames_reg <= cfg_data[cbsd_pkg::COOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pixel classification and saturating accumulation
    always_comb
    begin
        match = (pixel.hue >= hue_low_reg) && (pixel.hue <= hue_high_reg) &&
                (pixel.saturation >= sat_low_reg) && (pixel.brightness >= val_low_reg);
        col_clamped = (pixel.column > cbsd_pkg::COL_MAX) ? cbsd_pkg::COL_MAX
                                                         : pixel.column;
        sum_add = {1'b0, sum_reg} + (SW+1)'(col_clamped);
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.commit)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (fire && match)
        begin
            sum_next   = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
            count_next = (&count_reg) ? count_reg : count_reg + CW'(1);
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign rem_sub   = {1'b0, rem_shift} - {2'b00, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= '0;
            quo_reg  <= sum_reg;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[CW+1])
            begin
                rem_reg <= rem_sub[CW-1:0];
            end
            else
            begin
                rem_reg <= rem_shift[CW-1:0];
            end
            quo_reg  <= {quo_reg[SW-2:0], !rem_sub[CW+1]};
            step_reg <= step_reg + cbsd_pkg::DIV_STEP_W'(1);
        end
    end

    // frame-end decision
    always_comb
    begin
        seen = count_reg > CW'(min_area_reg);
        if (!seen)
        begin
            center = '0;
        end
        else if (|quo_reg[SW-1:cbsd_pkg::COL_W])
        begin
            center = {cbsd_pkg::COL_W{1'b1}};
        end
        else
        begin
            center = quo_reg[cbsd_pkg::COL_W-1:0];
        end
        diff     = $signed({2'b00, center}) - $signed({2'b00, last_center_reg});
        thr_s    = $signed({2'b00, thr_reg});
        swipe_ok = seen && last_valid_reg && (cooldown_reg == '0);
        go_next  = swipe_ok && (diff > thr_s);
        go_prev  = swipe_ok && (diff < -thr_s);
        priority if (go_next)
        begin
            gesture_next = cbsd_pkg::GEST_NEXT;
        end
        else if (go_prev)
        begin
            gesture_next = cbsd_pkg::GEST_PREV;
        end
        else
        begin
            gesture_next = cbsd_pkg::GEST_NONE;
        end
        cool_loaded   = (go_next || go_prev) ? cool_frames_reg : cooldown_reg;
        cooldown_next = (cool_loaded != '0) ? cool_loaded - cbsd_pkg::COOL_W'(1)
                                            : cool_loaded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            count_reg       <= '0;
            last_center_reg <= '0;
            last_valid_reg  <= 1'b0;
            cooldown_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            if (cmd.commit)
            begin
                cooldown_reg <= cooldown_next;
                if (seen)
                begin
                    last_center_reg <= center;
                    last_valid_reg  <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            gesture_reg  <= gesture_next;
            seen_reg     <= seen;
            centroid_reg <= center;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.gesture     = gesture_reg;
    assign result.marker_seen = seen_reg;
    assign result.centroid    = centroid_reg;

    assign status.last_fire = fire && pixel.frame_end;
    assign status.seen      = seen;
    assign status.div_done  = step_reg == cbsd_pkg::DIV_STEP_W'(cbsd_pkg::DIV_STEPS - 1);
    assign status.out_free  = !out_valid_reg || result.ready;

endmodule

[rtl/core/color_blob_swipe_detector_top.sv]
// Color blob swipe detector: per-frame marker centroid and left/right swipe.
// Throughput: one pixel beat per cycle inside a frame.
// Frame end: a last-pixel beat with a centroid has its result valid after
//   area check, restoring divide and commit; without a marker, area check and commit.
//   Pixel input stalls during that time and while the prior result is untaken.
// Reset (rst_n, async low): registers to defaults, accumulators, history clear.
module color_blob_swipe_detector_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    cbsd_pixel_if.sink                          pixel,
    cbsd_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [cbsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cbsd_pkg::cmd_t    cmd;
    cbsd_pkg::status_t status;
    cbsd_pkg::state_t  state;

    // Sequencer: owns the frame-end flow and gates pixel ready.
    cbsd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .state  (state)
    );

    // Datapath: accumulation, divide, swipe decision and result register.
    cbsd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    // A result beat appears only on the commit out of the done state,
    // where pixel input is held off.
    a_result_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> !$past(pixel.ready))
        else $error("result raised without frame-end processing");

    // The last pixel of a frame closes the input until the result commits.
    a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && pixel.frame_end) |=> !pixel.ready)
        else $error("pixel accepted right after frame end");

    // No marker means no gesture and a zero centroid.
    a_no_marker_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.marker_seen) |->
            (result.gesture == cbsd_pkg::GEST_NONE && result.centroid == '0))
        else $error("gesture or centroid reported without a marker");

    // Division only runs while the input is closed.
    a_divide_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state == cbsd_pkg::ST_DIVIDE) |-> (!pixel.ready && !result.valid ||
                                            !pixel.ready))
        else $error("pixel input open during divide");

endmodule

[tb/cbsd_frame_checker.sv]
// Frame checker: tracks pixel and config beats, predicts per-frame results, compares them.
module cbsd_frame_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    cbsd_pixel_if                               pix,
    cbsd_result_if                              res,
    input  logic                                cfg_we,
    input  logic [cbsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbsd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int unsigned                         fail_count,
    output int unsigned                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cbsd_pkg::*;

    typedef struct packed {
        gesture_t           gesture;
        logic               marker_seen;
        logic [COL_W-1:0]   centroid;
    } frame_result_t;

    frame_result_t expected_frames[$];
    int unsigned   mismatches;

    // register copy
    logic [HUE_W-1:0]  hue_lo, hue_hi;
    logic [SAT_W-1:0]  sat_lo;
    logic [VAL_W-1:0]  val_lo;
    logic [AREA_W-1:0] area_min;
    logic [THR_W-1:0]  swipe_thr;
    logic [COOL_W-1:0] lockout_load;

    // tracking state
    logic [SUM_W-1:0]  col_sum;
    logic [CNT_W-1:0]  px_count;
    logic [COL_W-1:0]  prev_center;
    logic              have_prev;
    logic [COOL_W-1:0] lockout;

    assign fail_count = mismatches;

    task automatic report(input string msg);
        $display("[%0t] frame check: %s", $time, msg);
        mismatches++;
    endtask

    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (cfg_index_t'(idx))
            CFG_HUE_LOW:   hue_lo       = data[HUE_W-1:0];
            CFG_HUE_HIGH:  hue_hi       = data[HUE_W-1:0];
            CFG_SAT_LOW:   sat_lo       = data[SAT_W-1:0];
            CFG_VAL_LOW:   val_lo       = data[VAL_W-1:0];
            CFG_MIN_AREA:  area_min     = data[AREA_W-1:0];
            CFG_SWIPE_THR: swipe_thr    = data[THR_W-1:0];
            CFG_COOLDOWN:  lockout_load = data[COOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic track_pixel(input logic [HUE_W-1:0] h, input logic [SAT_W-1:0] s,
                               input logic [VAL_W-1:0] v, input logic [COL_W-1:0] col_in,
                               input logic last);
        logic [COL_W-1:0] col;
        logic [SUM_W:0]   sum_ext;
        logic [SUM_W-1:0] quotient;
        frame_result_t    r;
        int               shift;
        col = (col_in > COL_MAX) ? COL_MAX : col_in;
        if (h >= hue_lo && h <= hue_hi && s >= sat_lo && v >= val_lo)
        begin
            sum_ext = {1'b0, col_sum} + (SUM_W+1)'(col);
            col_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (px_count != '1)
                px_count++;
        end
        if (!last)
            return;
        r = '{GEST_NONE, 1'b0, '0};
        if (px_count > area_min)
        begin
            r.marker_seen = 1'b1;
            quotient = col_sum / px_count;
            r.centroid = (quotient > 1023) ? '1 : quotient[COL_W-1:0];
            if (have_prev && lockout == 0)
            begin
                shift = int'(r.centroid) - int'(prev_center);
                if (shift > int'(swipe_thr))
                begin
                    r.gesture = GEST_NEXT;
                    lockout = lockout_load;
                end
                else if (shift < -int'(swipe_thr))
                begin
                    r.gesture = GEST_PREV;
                    lockout = lockout_load;
                end
            end
            prev_center = r.centroid;
            have_prev = 1'b1;
        end
        if (lockout != 0)
            lockout--;
        col_sum = '0;
        px_count = '0;
        expected_frames.push_back(r);
    endtask

    task automatic check_result();
        frame_result_t want;
        if (expected_frames.size() == 0)
        begin
            report("result beat with no frame end pending");
            return;
        end
        want = expected_frames.pop_front();
        if (res.gesture !== want.gesture)
            report($sformatf("gesture %0d, want %0d", res.gesture, want.gesture));
        if (res.marker_seen !== want.marker_seen)
            report($sformatf("marker_seen %0d, want %0d", res.marker_seen, want.marker_seen));
        if (res.centroid !== want.centroid)
            report($sformatf("centroid %0d, want %0d", res.centroid, want.centroid));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_lo       = HUE_LOW_RST;
            hue_hi       = HUE_HIGH_RST;
            sat_lo       = SAT_LOW_RST;
            val_lo       = VAL_LOW_RST;
            area_min     = MIN_AREA_RST;
            swipe_thr    = THR_RST;
            lockout_load = COOL_RST;
            col_sum      = '0;
            px_count     = '0;
            prev_center  = '0;
            have_prev    = 1'b0;
            lockout      = '0;
            expected_frames.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_cfg(cfg_index, cfg_data);
            // older frame first, then a possible new frame end
            if (res.valid && res.ready)
                check_result();
            if (pix.valid && pix.ready)
                track_pixel(pix.hue, pix.saturation, pix.brightness, pix.column,
                            pix.frame_end);
            pending <= expected_frames.size();
        end
    end

    initial
        mismatches = 0;

endmodule

[tb/color_blob_swipe_detector_top_tb.sv]
// Testbench top: pixel stimulus, config phases, result backpressure and verdict.
module color_blob_swipe_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbsd_pkg::*;

    // Leave margin after a frame end with a centroid before touching
    // registers or calling the run done.
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS  = 120;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            fail_count;
    int unsigned            pending;

    // Shadow of what we last programmed; shapes the marker pixels we generate.
    logic [CFG_DATA_W-1:0]  reg_val [0:6];

    // Set for the final phase: no gaps on the pixel side, no stalls on results.
    bit                     calm = 1'b0;

    cbsd_pixel_if  pix ();
    cbsd_result_if res ();

    color_blob_swipe_detector_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbsd_frame_checker frame_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hang guard: a run that has not finished by this time fails.
    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result sink: ready runs of random length broken by random stall bursts;
    // held high when calm. Long runs now and then give stretches with no stalls.
    initial
    begin
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                res.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                res.ready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 8))
                    @(posedge clk);
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    // One pixel beat; holds valid until the block takes it. Afterwards an
    // occasional gap burst, which may land mid-frame or during the divide.
    task automatic send_pixel(input int h, input int s, input int v, input int col,
                              input bit last);
        pix.valid      <= 1'b1;
        pix.hue        <= HUE_W'(h);
        pix.saturation <= SAT_W'(s);
        pix.brightness <= VAL_W'(v);
        pix.column     <= COL_W'(col);
        pix.frame_end  <= last;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // n identical marker pixels at one column, the last one closing the frame
    task automatic send_blob(input int col, input int n);
        for (int i = 0; i < n; i++)
            send_pixel(110, 200, 200, col, i == n - 1);
    endtask

    // Random frame: mostly marker pixels clustered around one column so the
    // centroid moves frame to frame, plus some noise pixels and stray columns.
    task automatic send_frame(input int n);
        int  center;
        int  col;
        int  h;
        int  s;
        int  v;
        int  hl;
        int  hh;
        center = $urandom_range(0, 1023);
        hl = int'(reg_val[CFG_HUE_LOW]);
        hh = int'(reg_val[CFG_HUE_HIGH]);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                h = (hl <= hh) ? $urandom_range(hl, hh) : $urandom_range(0, 179);
                s = $urandom_range(int'(reg_val[CFG_SAT_LOW]), 255);
                v = $urandom_range(int'(reg_val[CFG_VAL_LOW]), 255);
            end
            else
            begin
                h = $urandom_range(0, 179);
                s = $urandom_range(0, 255);
                v = $urandom_range(0, 255);
            end
            if ($urandom_range(0, 7) == 0)
                col = $urandom_range(0, 1023);
            else
            begin
                col = center + int'($urandom_range(0, 48)) - 24;
                col = (col < 0) ? 0 : (col > 1023) ? 1023 : col;
            end
            send_pixel(h, s, v, col, i == n - 1);
        end
    endtask

    // Writes every register from the shadow, one per cycle, block idle.
    task automatic program_regs();
        cfg_index_t idx;
        idx = idx.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_val[idx];
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we <= 1'b0;
    endtask

    // Stop sending, let every expected frame result come back, then settle.
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Per-phase register picks: all-minimum, then maximum with area 1048576, then an
    // empty hue window, then no lockout, then random small-area settings.
    task automatic choose_settings(input int phase);
        int hl;
        hl = $urandom_range(0, 179);
        reg_val[CFG_HUE_LOW]   = CFG_DATA_W'(hl);
        reg_val[CFG_HUE_HIGH]  = CFG_DATA_W'($urandom_range(hl, 179));
        reg_val[CFG_SAT_LOW]   = CFG_DATA_W'($urandom_range(0, 200));
        reg_val[CFG_VAL_LOW]   = CFG_DATA_W'($urandom_range(0, 200));
        reg_val[CFG_MIN_AREA]  = CFG_DATA_W'($urandom_range(0, 10));
        reg_val[CFG_SWIPE_THR] = CFG_DATA_W'($urandom_range(0, 400));
        reg_val[CFG_COOLDOWN]  = CFG_DATA_W'($urandom_range(0, 6));
        case (phase)
            0:
            begin
                reg_val[CFG_HUE_LOW]   = 0;
                reg_val[CFG_HUE_HIGH]  = 0;
                reg_val[CFG_SAT_LOW]   = 0;
                reg_val[CFG_VAL_LOW]   = 0;
                reg_val[CFG_MIN_AREA]  = 0;
                reg_val[CFG_SWIPE_THR] = 0;
                reg_val[CFG_COOLDOWN]  = 0;
            end
            1:
            begin
                reg_val[CFG_HUE_LOW]   = 179;
                reg_val[CFG_HUE_HIGH]  = 179;
                reg_val[CFG_SAT_LOW]   = 255;
                reg_val[CFG_VAL_LOW]   = 255;
                reg_val[CFG_MIN_AREA]  = 1048576;
                reg_val[CFG_SWIPE_THR] = 1023;
                reg_val[CFG_COOLDOWN]  = 255;
            end
            2:
            begin
                // low bound above high bound: nothing counts as marker
                reg_val[CFG_HUE_LOW]  = CFG_DATA_W'($urandom_range(1, 179));
                reg_val[CFG_HUE_HIGH] =
                    CFG_DATA_W'($urandom_range(0, int'(reg_val[CFG_HUE_LOW]) - 1));
            end
            3:
            begin
                reg_val[CFG_SWIPE_THR] = CFG_DATA_W'($urandom_range(0, 20));
                reg_val[CFG_COOLDOWN]  = 0;
            end
            default: ;
        endcase
    endtask

    initial
    begin
        int count;
        int n;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_HUE_LOW;
        cfg_data       = '0;
        pix.valid      = 1'b0;
        pix.hue        = '0;
        pix.saturation = '0;
        pix.brightness = '0;
        pix.column     = '0;
        pix.frame_end  = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: window 90..130, S/V floor 50, area above 2,
        // threshold 40, lockout 2, which blocks the next frame after a gesture.
        reg_val[CFG_HUE_LOW]   = 90;
        reg_val[CFG_HUE_HIGH]  = 130;
        reg_val[CFG_SAT_LOW]   = 50;
        reg_val[CFG_VAL_LOW]   = 50;
        reg_val[CFG_MIN_AREA]  = 2;
        reg_val[CFG_SWIPE_THR] = 40;
        reg_val[CFG_COOLDOWN]  = 2;
        program_regs();

        // first centroid, window and floor edges exactly on the bounds
        send_pixel(90, 50, 50, 0, 1'b0);
        send_pixel(130, 255, 255, 1023, 1'b0);
        send_pixel(110, 50, 50, 200, 1'b1);
        // just outside each bound, then a big jump right: next slide
        send_pixel(89, 255, 255, 0, 1'b0);
        send_pixel(179, 255, 255, 1023, 1'b0);
        send_pixel(110, 49, 255, 0, 1'b0);
        send_pixel(110, 255, 49, 0, 1'b0);
        send_blob(900, 3);
        // large move left while locked out: no gesture
        send_blob(10, 3);
        // lone non-marker pixel: nothing seen, history kept
        send_pixel(0, 0, 0, 0, 1'b1);
        send_blob(600, 3);
        send_pixel(0, 0, 0, 0, 1'b1);
        // lockout expired: move left gives previous slide
        send_blob(100, 3);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            choose_settings(phase);
            program_regs();
            calm = (phase == RANDOM_PHASES - 1);
            count = 0;
            while (count < PHASE_PIXELS)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60)
                                                : $urandom_range(1, 20);
                send_frame(n);
                count += n;
            end
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/cbsd_pkg.sv
rtl/core/cbsd_pixel_if.sv
rtl/core/cbsd_result_if.sv
rtl/core/cbsd_ctrl.sv
rtl/core/cbsd_datapath.sv
rtl/core/color_blob_swipe_detector_top.sv
tb/cbsd_frame_checker.sv
tb/color_blob_swipe_detector_top_tb.sv
